[src/zbpa_pkg.sv]
// ----------------------------------------------------------------------------
// zbpa_pkg
// Shared types and codes for the zoned bitmap page allocator.
// ----------------------------------------------------------------------------
package zbpa_pkg;

    localparam int GROUP_BITS    = 8;
    localparam int PAGE_NUMBER_W = 13;
    localparam int TOTAL_PAGES_W = 14;
    localparam int RESERVED_W    = 11;
    localparam int CFG_DATA_W    = 14;
    localparam int CFG_INDEX_W   = 1;
    localparam int STATUS_W      = 2;

    localparam logic [GROUP_BITS-1:0] GROUP_FULL  = 8'hFF;
    localparam logic [GROUP_BITS-1:0] GROUP_EMPTY = 8'h00;

    localparam logic [TOTAL_PAGES_W-1:0] TOTAL_PAGES_RST    = 14'd8192;
    localparam logic [RESERVED_W-1:0]    RESERVED_GROUPS_RST = 11'd1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_PAGES     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_GROUPS = 1'b1;

    // Opcodes
    localparam logic OP_INIT  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Zones
    localparam logic ZONE_DMA    = 1'b0;
    localparam logic ZONE_NORMAL = 1'b1;

    // Result status
    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INIT_DONE = 2'd2;

    typedef struct packed {
        logic opcode;
        logic zone;
    } cmd_t;

    typedef struct packed {
        logic [PAGE_NUMBER_W-1:0] page_number;
        logic                     zone_used;
        logic [STATUS_W-1:0]      status;
    } result_t;

endpackage

[src/zbpa_store.sv]
// ----------------------------------------------------------------------------
// zbpa_store
// Used-bit store: one byte per eight-page group, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module zbpa_store
    import zbpa_pkg::*;
#(
    parameter int MAX_PAGES = 8192
)
(
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(MAX_PAGES/8)-1:0]    waddr,
    input  logic [GROUP_BITS-1:0]             wdata,
    input  logic                              re,
    input  logic [$clog2(MAX_PAGES/8)-1:0]    raddr,
    output logic [GROUP_BITS-1:0]             rdata
);

    localparam int GROUPS = MAX_PAGES / 8;

    logic [GROUP_BITS-1:0] mem [GROUPS];
    logic [GROUP_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/zbpa_seq.sv]
// ----------------------------------------------------------------------------
// zbpa_seq
// Sequencer: store sweep for reset and init, first-fit group scan with
// one shared free-bit check, zone fallback and result register.
// ----------------------------------------------------------------------------
module zbpa_seq
    import zbpa_pkg::*;
#(
    parameter int MAX_PAGES = 8192,
    parameter int DMA_PAGES = 4096
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  cmd_t                              cmd,
    output logic                              busy,
    output logic                              done,
    output result_t                           result,
    input  logic [TOTAL_PAGES_W-1:0]          total_pages,
    input  logic [RESERVED_W-1:0]             reserved_groups,
    output logic                              mem_we,
    output logic [$clog2(MAX_PAGES/8)-1:0]    mem_waddr,
    output logic [GROUP_BITS-1:0]             mem_wdata,
    output logic                              mem_re,
    output logic [$clog2(MAX_PAGES/8)-1:0]    mem_raddr,
    input  logic [GROUP_BITS-1:0]             mem_rdata
);

    localparam int GROUPS   = MAX_PAGES / 8;
    localparam int GW       = $clog2(GROUPS);
    localparam int CW       = GW + 1;
    localparam int NW       = ($clog2(MAX_PAGES + 1) > TOTAL_PAGES_W) ?
                              $clog2(MAX_PAGES + 1) : TOTAL_PAGES_W;
    localparam int RW       = (CW > RESERVED_W) ? CW : RESERVED_W;
    localparam int DMA_CLIP = (DMA_PAGES < MAX_PAGES) ? DMA_PAGES : MAX_PAGES;
    localparam int PW       = GW + 3;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_SCAN  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   end_reg, end_next;
    logic [CW-1:0]   dma_end_reg, dma_end_next;
    logic [CW-1:0]   lim_reg, lim_next;
    logic            init_reg, init_next;
    logic            normal_reg, normal_next;
    logic [GW-1:0]   chk_reg, chk_next;
    logic            chk_vld_reg, chk_vld_next;
    logic            done_reg, done_next;
    result_t         result_reg, result_next;

    // zone bounds from the current registers
    logic [NW-1:0]   tp_ext, eff_pages, dma_pages;
    logic [CW-1:0]   dma_groups, normal_groups, normal_end, res_clip;

    // shared free-bit check
    logic            grp_free;
    logic [2:0]      free_bit;
    logic [PW-1:0]   page_full;

    always_comb
    begin
        tp_ext        = NW'(total_pages);
        eff_pages     = (tp_ext > NW'(MAX_PAGES)) ? NW'(MAX_PAGES) : tp_ext;
        dma_pages     = (eff_pages > NW'(DMA_CLIP)) ? NW'(DMA_CLIP) : eff_pages;
        dma_groups    = CW'(dma_pages >> 3);
        normal_groups = CW'((eff_pages - dma_pages) >> 3);
        normal_end    = dma_groups + normal_groups;
        res_clip      = (RW'(reserved_groups) > RW'(GROUPS)) ?
                        CW'(GROUPS) : CW'(reserved_groups);
    end

    always_comb
    begin
        free_bit = 3'd0;
        for (int b = GROUP_BITS - 1; b >= 0; b--)
        begin
            if (!mem_rdata[b])
            begin
                free_bit = 3'(b);
            end
        end
        grp_free  = chk_vld_reg && (mem_rdata != GROUP_FULL);
        page_full = {chk_reg, free_bit};
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        end_next     = end_reg;
        dma_end_next = dma_end_reg;
        lim_next     = lim_reg;
        init_next    = init_reg;
        normal_next  = normal_reg;
        chk_next     = chk_reg;
        chk_vld_next = chk_vld_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mem_we       = 1'b0;
        mem_waddr    = cnt_reg[GW-1:0];
        mem_wdata    = GROUP_EMPTY;
        mem_re       = 1'b0;
        mem_raddr    = cnt_reg[GW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cnt_next     = '0;
                    chk_vld_next = 1'b0;
                    if (cmd.opcode == OP_INIT)
                    begin
                        lim_next   = res_clip;
                        init_next  = 1'b1;
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        dma_end_next = dma_groups;
                        if (cmd.zone == ZONE_NORMAL)
                        begin
                            normal_next = 1'b1;
                            cnt_next    = dma_groups;
                            end_next    = normal_end;
                        end
                        else
                        begin
                            normal_next = 1'b0;
                            end_next    = dma_groups;
                        end
                        state_next = S_SCAN;
                    end
                end
            end

            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_wdata = (cnt_reg < lim_reg) ? GROUP_FULL : GROUP_EMPTY;
                if (cnt_reg == CW'(GROUPS - 1))
                begin
                    state_next = S_IDLE;
                    if (init_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = '{page_number: '0, zone_used: ZONE_DMA,
                                        status: ST_INIT_DONE};
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_SCAN:
            begin
                if (grp_free)
                begin
                    // take lowest free bit of the checked group
                    mem_we      = 1'b1;
                    mem_waddr   = chk_reg;
                    mem_wdata   = mem_rdata | (GROUP_BITS'(1) << free_bit);
                    done_next   = 1'b1;
                    result_next = '{page_number: PAGE_NUMBER_W'(page_full),
                                    zone_used: normal_reg, status: ST_ALLOCATED};
                    chk_vld_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else if (cnt_reg < end_reg)
                begin
                    mem_re       = 1'b1;
                    chk_next     = cnt_reg[GW-1:0];
                    chk_vld_next = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    if (!chk_vld_reg)
                    begin
                        if (normal_reg)
                        begin
                            // normal zone exhausted: fall back to DMA
                            normal_next = 1'b0;
                            cnt_next    = '0;
                            end_next    = dma_end_reg;
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            result_next = '{page_number: '0, zone_used: ZONE_DMA,
                                            status: ST_EXHAUSTED};
                            state_next  = S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_SWEEP;
            cnt_reg     <= '0;
            lim_reg     <= '0;
            init_reg    <= 1'b0;
            chk_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            normal_reg  <= 1'b0;
            end_reg     <= '0;
            dma_end_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            lim_reg     <= lim_next;
            init_reg    <= init_next;
            chk_vld_reg <= chk_vld_next;
            done_reg    <= done_next;
            normal_reg  <= normal_next;
            end_reg     <= end_next;
            dma_end_reg <= dma_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg    <= chk_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // ---- checks ----
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE))
        else $error("result strobe without preceding work");

    a_write_when_active: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_SWEEP || state_reg == S_SCAN))
        else $error("store write while idle");

    a_alloc_wrote: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status == ST_ALLOCATED) |-> $past(mem_we))
        else $error("page handed out without marking it used");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= end_reg && end_reg <= CW'(GROUPS)))
        else $error("scan pointer past zone end");

endmodule

[src/zoned_bitmap_page_allocator.sv]
// ----------------------------------------------------------------------------
// zoned_bitmap_page_allocator
// Allocate scans one group per cycle through the single store read port and
//   free-bit check, falls back from the normal zone to DMA, or reports exhausted.
// Init runs a sweep that writes every group once.
// After reset the same sweep clears the store, with busy high.
// One item at a time; each result is a one-cycle done strobe, never stalled.
// ----------------------------------------------------------------------------
module zoned_bitmap_page_allocator
    import zbpa_pkg::*;
#(
    parameter int MAX_PAGES = 8192,
    parameter int DMA_PAGES = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // command channel: transfer on start && !busy
    input  logic                   start,
    input  cmd_t                   cmd,
    output logic                   busy,
    // result channel: transfer on done, one cycle
    output logic                   done,
    output result_t                result,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int GW = $clog2(MAX_PAGES / 8);

    // Configuration registers; zone bounds follow them on every allocate,
    // so a write takes effect without a fresh init.
    logic [TOTAL_PAGES_W-1:0] total_pages_reg, total_pages_next;
    logic [RESERVED_W-1:0]    reserved_groups_reg, reserved_groups_next;

    // store port
    logic                     mem_we;
    logic [GW-1:0]            mem_waddr;
    logic [GROUP_BITS-1:0]    mem_wdata;
    logic                     mem_re;
    logic [GW-1:0]            mem_raddr;
    logic [GROUP_BITS-1:0]    mem_rdata;

    always_comb
    begin
        total_pages_next     = total_pages_reg;
        reserved_groups_next = reserved_groups_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TOTAL_PAGES:
                begin
                    total_pages_next = cfg_wdata[TOTAL_PAGES_W-1:0];
                end
                REG_RESERVED_GROUPS:
                begin
                    reserved_groups_next = cfg_wdata[RESERVED_W-1:0];
                end
                default:
                begin
                    total_pages_next = total_pages_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg     <= TOTAL_PAGES_RST;
            reserved_groups_reg <= RESERVED_GROUPS_RST;
        end
        else
        begin
            total_pages_reg     <= total_pages_next;
            reserved_groups_reg <= reserved_groups_next;
        end
    end

    // Sequencer: sweep, first-fit scan, fallback, result register
    zbpa_seq #(
        .MAX_PAGES (MAX_PAGES),
        .DMA_PAGES (DMA_PAGES)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .cmd             (cmd),
        .busy            (busy),
        .done            (done),
        .result          (result),
        .total_pages     (total_pages_reg),
        .reserved_groups (reserved_groups_reg),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    // Used-bit store, one byte per group
    zbpa_store #(
        .MAX_PAGES (MAX_PAGES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

[tb/page_alloc_sb_pkg.sv]
// ----------------------------------------------------------------------------
// page_alloc_sb_pkg
// Scoreboard for the zoned page allocator. It keeps its own copy of the
// used-bit store and both registers, works out the grant for each command
// taken in, and compares every done strobe against the oldest one waiting.
// ----------------------------------------------------------------------------
package page_alloc_sb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import zbpa_pkg::*;

    localparam int unsigned MAX_PAGES = 8192;
    localparam int unsigned DMA_PAGES = 4096;
    localparam int unsigned GROUPS    = MAX_PAGES / GROUP_BITS;

    class page_alloc_scoreboard;

        logic [GROUP_BITS-1:0]    used_map [GROUPS];
        logic [TOTAL_PAGES_W-1:0] total_pages;
        logic [RESERVED_W-1:0]    reserved_groups;
        result_t                  awaited_grants [$];

        int unsigned commands;
        int unsigned inits;
        int unsigned dma_grants;
        int unsigned normal_grants;
        int unsigned exhausted;
        int unsigned errors;

        function new();
            foreach (used_map[g])
                used_map[g] = GROUP_EMPTY;
            total_pages     = TOTAL_PAGES_RST;
            reserved_groups = RESERVED_GROUPS_RST;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] data);
            if (index == REG_TOTAL_PAGES)
                total_pages = data[TOTAL_PAGES_W-1:0];
            else if (index == REG_RESERVED_GROUPS)
                reserved_groups = data[RESERVED_W-1:0];
        endfunction

        // first-fit over groups [base, base+count), stops at the store end
        function bit take_first_free(int unsigned base, int unsigned count,
                                     output int unsigned page);
            int unsigned idx;
            page = 0;
            for (int unsigned g = 0; g < count; g++)
            begin
                idx = base + g;
                if (idx >= GROUPS)
                    return 1'b0;
                if (used_map[idx] != GROUP_FULL)
                    for (int b = 0; b < GROUP_BITS; b++)
                        if (!used_map[idx][b])
                        begin
                            used_map[idx][b] = 1'b1;
                            page = idx * GROUP_BITS + b;
                            return 1'b1;
                        end
            end
            return 1'b0;
        endfunction

        function void note_command(cmd_t c);
            result_t     want;
            int unsigned eff;
            int unsigned dma;
            int unsigned page;
            int unsigned held;
            want = '0;
            commands++;
            if (c.opcode == OP_INIT)
            begin
                held = (reserved_groups > GROUPS) ? GROUPS : reserved_groups;
                foreach (used_map[g])
                    used_map[g] = (g < held) ? GROUP_FULL : GROUP_EMPTY;
                want.status = ST_INIT_DONE;
                inits++;
            end
            else
            begin
                // zone bounds follow the live register, not the last init
                eff = (total_pages > MAX_PAGES) ? MAX_PAGES : total_pages;
                dma = (eff > DMA_PAGES) ? DMA_PAGES : eff;
                if (c.zone == ZONE_NORMAL &&
                    take_first_free(dma >> 3, (eff - dma) / GROUP_BITS, page))
                begin
                    want.page_number = page[PAGE_NUMBER_W-1:0];
                    want.zone_used   = ZONE_NORMAL;
                    want.status      = ST_ALLOCATED;
                    normal_grants++;
                end
                else if (take_first_free(0, dma / GROUP_BITS, page))
                begin
                    want.page_number = page[PAGE_NUMBER_W-1:0];
                    want.zone_used   = ZONE_DMA;
                    want.status      = ST_ALLOCATED;
                    dma_grants++;
                end
                else
                begin
                    want.status = ST_EXHAUSTED;
                    exhausted++;
                end
            end
            awaited_grants.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_grant(result_t got);
            result_t want;
            if (awaited_grants.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got page %0d zone %0d status %0d",
                         $time, got.page_number, got.zone_used, got.status);
                errors++;
                return;
            end
            want = awaited_grants.pop_front();
            compare_field("page_number", want.page_number, got.page_number);
            compare_field("zone_used", want.zone_used, got.zone_used);
            compare_field("status", want.status, got.status);
        endfunction

        function int unsigned pending();
            return awaited_grants.size();
        endfunction

    endclass

endpackage

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the zoned bitmap page allocator with a directed set of commands
// (allocate before init, fallback, partial groups, exhaustion, saturating
// registers) and then random phases of register settings, inits and
// allocations. Every done strobe is checked against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import zbpa_pkg::*;
    import page_alloc_sb_pkg::*;

    localparam int unsigned DIRECTED_ITEMS = 25;
    localparam int unsigned RANDOM_ITEMS   = 1050;
    localparam int unsigned PLANNED_ITEMS  = DIRECTED_ITEMS + RANDOM_ITEMS;
    // worst allocate or init is a full sweep of the store; the limit covers
    // every planned item at that cost with room to spare
    localparam int unsigned CYCLE_LIMIT    = 5_000_000;
    localparam int unsigned DRAIN_CYCLES   = MAX_PAGES / GROUP_BITS + 16;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    cmd_t                   cmd;
    logic                   busy;
    logic                   done;
    result_t                result;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    page_alloc_scoreboard sb;
    int unsigned          reg_writes;
    int unsigned          cycles;

    zoned_bitmap_page_allocator #(
        .MAX_PAGES (MAX_PAGES),
        .DMA_PAGES (DMA_PAGES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("testbench failed");
            $finish;
        end
    end

    // result side: a done strobe is a transfer, the receiver cannot stall it
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_grant(result);
    end

    // One command transfer. Entered and left at a falling edge; start is left
    // high so back-to-back commands need no extra step. The sender gap
    // follows the item count: 34 in 100, then 48 in 100, then none.
    task automatic issue(input logic op, input logic zn);
        int unsigned gap_pct;
        cmd_t        c;
        c.opcode = op;
        c.zone   = zn;
        gap_pct = (sb.commands < PLANNED_ITEMS / 3)     ? 34 :
                  (sb.commands < 2 * PLANNED_ITEMS / 3) ? 48 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        // busy is read before the edge updates it
        do @(posedge clk); while (busy);
        sb.note_command(c);
        @(negedge clk);
    endtask

    // Drop start and wait until every grant is back and the block is idle.
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_register(index, data);
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic directed_run();
        // store is clear after reset: allocate before any init
        issue(OP_ALLOC, ZONE_DMA);
        issue(OP_ALLOC, ZONE_NORMAL);
        // zone bit is a don't-care on init
        issue(OP_INIT, ZONE_NORMAL);
        issue(OP_ALLOC, ZONE_DMA);
        issue(OP_ALLOC, ZONE_NORMAL);

        // one full DMA group plus a partial one, no normal zone at all
        settle();
        write_reg(REG_TOTAL_PAGES, 14'd12);
        write_reg(REG_RESERVED_GROUPS, 14'd0);
        issue(OP_INIT, ZONE_DMA);
        issue(OP_ALLOC, ZONE_NORMAL);       // falls back to DMA
        repeat (7)
            issue(OP_ALLOC, ZONE_DMA);
        issue(OP_ALLOC, ZONE_NORMAL);       // trailing pages never given out
        issue(OP_ALLOC, ZONE_DMA);

        // both registers beyond the store: size and reservation saturate
        settle();
        write_reg(REG_TOTAL_PAGES, 14'h3FFF);
        write_reg(REG_RESERVED_GROUPS, 14'd2047);
        issue(OP_INIT, ZONE_DMA);
        issue(OP_ALLOC, ZONE_NORMAL);
        issue(OP_ALLOC, ZONE_DMA);

        // no pages installed; bounds change takes effect without an init
        settle();
        write_reg(REG_TOTAL_PAGES, 14'd0);
        write_reg(REG_RESERVED_GROUPS, 14'd0);
        issue(OP_ALLOC, ZONE_NORMAL);
        issue(OP_INIT, ZONE_DMA);
        issue(OP_ALLOC, ZONE_DMA);

        // DMA fully reserved, normal zone shorter than one group
        settle();
        write_reg(REG_TOTAL_PAGES, 14'd4100);
        write_reg(REG_RESERVED_GROUPS, 14'd512);
        issue(OP_INIT, ZONE_NORMAL);
        issue(OP_ALLOC, ZONE_NORMAL);
        issue(OP_ALLOC, ZONE_DMA);
    endtask

    // Random phases: mostly a register setting, an init and a run of
    // allocations; now and then the init is skipped or lands mid-run.
    task automatic random_run();
        int unsigned              pick;
        int unsigned              n_alloc;
        logic [TOTAL_PAGES_W-1:0] tp;
        logic [RESERVED_W-1:0]    rg;
        while (sb.commands < PLANNED_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                tp = TOTAL_PAGES_W'($urandom_range(0, 72));         // tiny, exhausts quickly
            else if (pick < 6)
                tp = TOTAL_PAGES_W'(4096 + $urandom_range(0, 120)); // short normal zone
            else if (pick < 8)
                tp = TOTAL_PAGES_W'($urandom_range(0, 16383));
            else if (pick == 8)
                tp = 14'd8192;
            else
                tp = $urandom_range(0, 1) ? 14'h3FFF : 14'd0;

            pick = $urandom_range(0, 9);
            if (pick < 6)
                rg = RESERVED_W'($urandom_range(0, 12));
            else if (pick < 8)
                rg = RESERVED_W'($urandom_range(0, 520));
            else if (pick == 8)
                rg = RESERVED_W'($urandom_range(0, 2047));
            else
                rg = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;

            settle();
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_TOTAL_PAGES, tp);
            // unused upper data bits carry noise
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_RESERVED_GROUPS,
                          {3'($urandom_range(0, 7)), rg});
            if ($urandom_range(0, 7) != 0)
                issue(OP_INIT, 1'($urandom_range(0, 1)));

            n_alloc = $urandom_range(8, 64);
            repeat (n_alloc)
            begin
                if ($urandom_range(0, 29) == 0)
                    issue(OP_INIT, 1'($urandom_range(0, 1)));
                else
                    issue(OP_ALLOC, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        sb        = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // clearing sweep after reset holds busy high
        settle();

        directed_run();
        random_run();

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d commands, %0d inits, %0d register writes",
                 sb.commands, sb.inits, reg_writes);
        $display("pages granted: %0d normal, %0d DMA; %0d exhausted replies; %0d errors",
                 sb.normal_grants, sb.dma_grants, sb.exhausted, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[zoned_bitmap_page_allocator.f]
src/zbpa_pkg.sv
src/zbpa_store.sv
src/zbpa_seq.sv
src/zoned_bitmap_page_allocator.sv
tb/page_alloc_sb_pkg.sv
tb/testbench.sv
